// ===== rtl/core/hbd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hbd_pkg: shared definitions of the prefix-code bit decoder
// Field widths, request and status codes, and the sequencer state type.
// ----------------------------------------------------------------------------
package hbd_pkg;

  localparam int REQ_W  = 2;
  localparam int SYM_W  = 8;
  localparam int CODE_W = 32;
  localparam int LEN_W  = 6;
  localparam int BYTE_W = 8;
  localparam int VB_W   = 4;
  localparam int STAT_W = 2;

  // request types
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DATA  = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_SYMBOL   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_LEFTOVER = 2'd1;
  localparam logic [STAT_W-1:0] STAT_TOO_LONG = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SHIFT  = 5'b00010,
    S_SCAN   = 5'b00100,
    S_PUSH   = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

endpackage : hbd_pkg
`default_nettype wire

// ===== rtl/core/huffman_bit_decoder_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// huffman_bit_decoder_top: prefix-code decoder with a searched code table
// Takes clear, load and compressed-byte requests and returns decoded symbols.
// ----------------------------------------------------------------------------
// A clear request empties the code table and the bit accumulator; a load
// request stores one symbol's code and length; a data request shifts the
// leading valid bits of a byte, MSB first, into the accumulator. After every
// bit the code table RAM is scanned from symbol 0 upward, one entry per
// cycle, and the first entry whose length and code equal the accumulated bits
// is emitted. The table RAM has a single read port and one shared compare;
// a match ends a scan early. The block accepts no request while a data
// request is in work. Each result is held back one step so that the last
// result of a request can carry last_of_item; one result waits in that
// pending slot and one in the output register, so a stalled consumer stops
// the sequencer once both of them are full and a further result is ready or
// the request ends.
// ----------------------------------------------------------------------------
module huffman_bit_decoder_top
  import hbd_pkg::*;
#(
  parameter int TABLE_DEPTH  = 256,
  parameter int MAX_CODE_LEN = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  // request channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [REQ_W-1:0]  in_req_type,
  input  logic [SYM_W-1:0]  in_entry_symbol,
  input  logic [CODE_W-1:0] in_entry_code,
  input  logic [LEN_W-1:0]  in_entry_length,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic [VB_W-1:0]   in_valid_bits,
  input  logic              in_end_of_stream,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [SYM_W-1:0]  out_symbol,
  output logic [STAT_W-1:0] out_status,
  output logic              out_last_of_item
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int ACC_W = MAX_CODE_LEN;
  localparam int CNT_W = $clog2(MAX_CODE_LEN + 1);
  localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam int RAM_W = LEN_W + CODE_W;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_CODE_LEN);

  // sequencer and bit source
  state_t             state_r, state_nxt;
  logic [BYTE_W-1:0]  byte_r, byte_nxt;
  logic [VB_W-1:0]    bits_left_r, bits_left_nxt;
  logic               eos_r, eos_nxt;

  // accumulator: acc_mask_r has one set bit per accumulated bit
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [ACC_W-1:0]   acc_mask_r, acc_mask_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  // table scan: issue side and check side of the registered RAM read
  logic [IDX_W-1:0]   scan_idx_r, scan_idx_nxt;
  logic               issue_done_r, issue_done_nxt;
  logic               issue;
  logic               chk_vld_r;
  logic [IDX_W-1:0]   chk_idx_r;
  logic               chk_ent_vld_r;
  logic [TABLE_DEPTH-1:0] ent_vld_r, ent_vld_nxt;

  // newest result, pending result and output register
  logic [SYM_W-1:0]   new_sym_r, new_sym_nxt;
  logic [STAT_W-1:0]  new_status_r, new_status_nxt;
  logic               pend_vld_r, pend_vld_nxt;
  logic [SYM_W-1:0]   pend_sym_r, pend_sym_nxt;
  logic [STAT_W-1:0]  pend_status_r, pend_status_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0]   out_symbol_r;
  logic [STAT_W-1:0]  out_status_r;
  logic               out_last_r;
  logic               out_load;
  logic               out_load_last;
  logic               out_free;

  // table RAM
  logic               ram_we;
  logic [RAM_W-1:0]   ram_rdata;
  logic [CODE_W-1:0]  rd_code;
  logic [LEN_W-1:0]   rd_len;
  logic               sym_in_range;
  logic               hit;
  logic               exhausted;

  hbd_ram #(
    .WIDTH (RAM_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_entry_symbol[IDX_W-1:0]),
    .wdata ({in_entry_length, in_entry_code}),
    .raddr (scan_idx_r),
    .rdata (ram_rdata)
  );

  assign rd_code = ram_rdata[CODE_W-1:0];
  assign rd_len  = ram_rdata[RAM_W-1:CODE_W];

  assign in_ready  = (state_r == S_IDLE);
  assign out_free  = !out_valid_r || out_ready;
  assign issue     = (state_r == S_SCAN) && !issue_done_r;
  assign sym_in_range = ({1'b0, in_entry_symbol} < (SYM_W + 1)'(TABLE_DEPTH));

  // the count is never zero during a scan, so an equal length is nonzero
  // and no longer than the limit
  assign hit = chk_vld_r && chk_ent_vld_r
            && (CMP_W'(rd_len) == CMP_W'(cnt_r))
            && ((ACC_W'(rd_code) & acc_mask_r) == acc_r);
  assign exhausted = chk_vld_r && (chk_idx_r == LAST_IDX) && !hit;

  always_comb begin
    state_nxt       = state_r;
    byte_nxt        = byte_r;
    bits_left_nxt   = bits_left_r;
    eos_nxt         = eos_r;
    acc_nxt         = acc_r;
    acc_mask_nxt    = acc_mask_r;
    cnt_nxt         = cnt_r;
    scan_idx_nxt    = scan_idx_r;
    issue_done_nxt  = issue_done_r;
    ent_vld_nxt     = ent_vld_r;
    new_sym_nxt     = new_sym_r;
    new_status_nxt  = new_status_r;
    pend_vld_nxt    = pend_vld_r;
    pend_sym_nxt    = pend_sym_r;
    pend_status_nxt = pend_status_r;
    ram_we          = 1'b0;
    out_load        = 1'b0;
    out_load_last   = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_req_type)
            REQ_CLEAR: begin
              ent_vld_nxt  = '0;
              acc_nxt      = '0;
              acc_mask_nxt = '0;
              cnt_nxt      = '0;
            end
            REQ_LOAD: begin
              if (sym_in_range) begin
                ram_we = 1'b1;
                ent_vld_nxt[in_entry_symbol[IDX_W-1:0]] = 1'b1;
              end
            end
            REQ_DATA: begin
              byte_nxt      = in_data_byte;
              bits_left_nxt = (in_valid_bits > VB_W'(BYTE_W)) ? VB_W'(BYTE_W)
                                                              : in_valid_bits;
              eos_nxt       = in_end_of_stream;
              state_nxt     = S_SHIFT;
            end
            default: begin
              // unknown request: drop
            end
          endcase
        end
      end

      S_SHIFT: begin
        if (bits_left_r == '0) begin
          state_nxt = S_FINISH;
        end else begin
          acc_nxt        = {acc_r[ACC_W-2:0], byte_r[BYTE_W-1]};
          acc_mask_nxt   = {acc_mask_r[ACC_W-2:0], 1'b1};
          cnt_nxt        = cnt_r + CNT_W'(1);
          byte_nxt       = {byte_r[BYTE_W-2:0], 1'b0};
          bits_left_nxt  = bits_left_r - VB_W'(1);
          scan_idx_nxt   = '0;
          issue_done_nxt = 1'b0;
          state_nxt      = S_SCAN;
        end
      end

      S_SCAN: begin
        if (issue) begin
          if (scan_idx_r == LAST_IDX) begin
            issue_done_nxt = 1'b1;
          end else begin
            scan_idx_nxt = scan_idx_r + IDX_W'(1);
          end
        end
        if (hit) begin
          new_sym_nxt    = SYM_W'(chk_idx_r);
          new_status_nxt = STAT_SYMBOL;
          acc_nxt        = '0;
          acc_mask_nxt   = '0;
          cnt_nxt        = '0;
          state_nxt      = S_PUSH;
        end else if (exhausted) begin
          if (cnt_r == CNT_MAX) begin
            new_sym_nxt    = '0;
            new_status_nxt = STAT_TOO_LONG;
            acc_nxt        = '0;
            acc_mask_nxt   = '0;
            cnt_nxt        = '0;
            state_nxt      = S_PUSH;
          end else begin
            state_nxt = S_SHIFT;
          end
        end
      end

      S_PUSH: begin
        if (!pend_vld_r) begin
          pend_vld_nxt    = 1'b1;
          pend_sym_nxt    = new_sym_r;
          pend_status_nxt = new_status_r;
          state_nxt       = S_SHIFT;
        end else if (out_free) begin
          out_load        = 1'b1;
          pend_sym_nxt    = new_sym_r;
          pend_status_nxt = new_status_r;
          state_nxt       = S_SHIFT;
        end
      end

      S_FINISH: begin
        if (eos_r && (cnt_r != '0)) begin
          new_sym_nxt    = '0;
          new_status_nxt = STAT_LEFTOVER;
          acc_nxt        = '0;
          acc_mask_nxt   = '0;
          cnt_nxt        = '0;
          eos_nxt        = 1'b0;
          state_nxt      = S_PUSH;
        end else if (pend_vld_r) begin
          if (out_free) begin
            out_load      = 1'b1;
            out_load_last = 1'b1;
            pend_vld_nxt  = 1'b0;
            state_nxt     = S_IDLE;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      acc_r        <= '0;
      acc_mask_r   <= '0;
      cnt_r        <= '0;
      issue_done_r <= 1'b1;
      chk_vld_r    <= 1'b0;
      ent_vld_r    <= '0;
      pend_vld_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      acc_r        <= acc_nxt;
      acc_mask_r   <= acc_mask_nxt;
      cnt_r        <= cnt_nxt;
      issue_done_r <= issue_done_nxt;
      chk_vld_r    <= issue;
      ent_vld_r    <= ent_vld_nxt;
      pend_vld_r   <= pend_vld_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    byte_r        <= byte_nxt;
    bits_left_r   <= bits_left_nxt;
    eos_r         <= eos_nxt;
    scan_idx_r    <= scan_idx_nxt;
    chk_idx_r     <= scan_idx_r;
    chk_ent_vld_r <= ent_vld_r[scan_idx_r];
    new_sym_r     <= new_sym_nxt;
    new_status_r  <= new_status_nxt;
    pend_sym_r    <= pend_sym_nxt;
    pend_status_r <= pend_status_nxt;
    if (out_load) begin
      out_symbol_r <= pend_sym_r;
      out_status_r <= pend_status_r;
      out_last_r   <= out_load_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_symbol       = out_symbol_r;
  assign out_status       = out_status_r;
  assign out_last_of_item = out_last_r;

  // a result never stays pending once the request is done
  a_no_pend_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_vld_r)
    else $error("pending result left behind at end of request");

  // accumulator holds no bits above the accumulated count
  a_acc_in_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_r & ~acc_mask_r) == '0)
    else $error("accumulator has bits outside its mask");

  // a scan always works on at least one accumulated bit, never above the limit
  a_scan_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> ((cnt_r != '0) && (cnt_r <= CNT_MAX)))
    else $error("scan with empty or overfull accumulator");

endmodule : huffman_bit_decoder_top
`default_nettype wire

// ===== rtl/core/hbd_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hbd_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module hbd_ram #(
  parameter int WIDTH = 38,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : hbd_ram
`default_nettype wire
